// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the project, included by the core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Condition holds at every edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition");
// Antecedent implies consequent in the same cycle
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define AST_HOLDS(lbl, clk, rst_n, cond)
`define AST_IMPLIES(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wtgt_pkg.sv =====
// Types, constants and the arctangent table of the wind triangle core.
package wtgt_pkg;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [22:0] cfg_data_t;

  // Register indexes
  localparam cfg_idx_t CFG_AIR_SPEED  = 3'd0;
  localparam cfg_idx_t CFG_BASE_WIND  = 3'd1;
  localparam cfg_idx_t CFG_WIND_DIR   = 3'd2;
  localparam cfg_idx_t CFG_FLUC_PER   = 3'd3;
  localparam cfg_idx_t CFG_FLUC_MODE  = 3'd4;

  // Fluctuation modes
  localparam logic [1:0] FM_CONST = 2'd0;
  localparam logic [1:0] FM_SAW   = 2'd1;
  localparam logic [1:0] FM_PULSE = 2'd2;
  localparam logic [1:0] FM_RSVD  = 2'd3;  // unused code, wind held

  localparam logic [18:0] MAX_WIND_Q16 = 19'd265420;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [36:0] TWO_PI_Q32  = 37'sd26986075409;
  localparam logic signed [36:0] PI_Q32      = 37'sd13493037705;
  localparam logic [49:0] RED_CMP0 = 50'd26986075409 << 14;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [60:0] SQ_ONE = 61'd1 << 60;

  // atan(2^-i) in Q16.16
  function automatic logic [15:0] atan_q16(input logic [5:0] i);
    logic [15:0] v;
    v = '0;
    case (i)
      6'd0: v = 16'd51472;
      6'd1: v = 16'd30386;
      6'd2: v = 16'd16055;
      6'd3: v = 16'd8150;
      6'd4: v = 16'd4091;
      6'd5: v = 16'd2047;
      6'd6: v = 16'd1024;
      default: begin
        if (i <= 6'd16) v = 16'h8000 >> (i - 6'd1);
      end
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/wtgt_if.sv =====
// Handshake channel interfaces for heading requests and ground track results.
interface wtgt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] heading_in;
  logic signed [31:0] gps_corr;
  modport source (output valid, heading_in, gps_corr, input ready);
  modport sink   (input valid, heading_in, gps_corr, output ready);
endinterface

interface wtgt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gnd_speed;
  logic signed [31:0] distance_step;
  logic signed [31:0] heading_out;
  modport source (output valid, gnd_speed, distance_step, heading_out, input ready);
  modport sink   (input valid, gnd_speed, distance_step, heading_out, output ready);
endinterface

// ===== hw/rtl/wind_triangle_ground_track_core.sv =====
// Wind triangle ground track core: wind fluctuation, CORDIC wind triangle solve.
//
// One request at a time: a heading and GPS error sample go in, one result with
// ground speed, distance step and corrected heading comes out, all signed Q16.16.
// Sawtooth mode adds a wind division, and an asin argument that needs a true
// division by the airspeed adds a second one. One sequencer drives a shared
// restoring divider, a 15-step modulo-2pi reduction, a shared CORDIC stage
// (rotation for sin/cos, then vectoring for asin), a 31-step square root and one
// shared 34x34 multiplier. The result sits in an output register, so a new
// request is taken once the sequencer is back in idle. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while the core is idle;
// the core itself does not enforce this.
`include "assert_macros.svh"

module wind_triangle_ground_track_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  wtgt_in_if.sink             in_ch,
  wtgt_out_if.source          out_ch,
  input  logic                cfg_we,
  input  wtgt_pkg::cfg_idx_t  cfg_index,
  input  wtgt_pkg::cfg_data_t cfg_data
);
  import wtgt_pkg::*;

  localparam int CIW = $clog2(CORDIC_STEPS);
  localparam logic [5:0] CLAST = 6'(CORDIC_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WIND, S_DIV, S_RED, S_FOLD, S_ROT, S_MWS, S_ARG,
    S_SQR, S_SQI, S_SQRT, S_VEC, S_GS1, S_GS2, S_FIN
  } state_t;

  state_t state_r;

  // Configuration and wind state
  logic [22:0]        air_r;
  logic [18:0]        base_r;
  logic signed [19:0] dir_r;
  logic [15:0]        period_r;
  logic [1:0]         mode_r;
  logic [15:0]        tick_r;
  logic               odd_r;
  logic [19:0]        wind_r;

  // Request payload
  logic signed [31:0] h_r, gps_r;

  // Datapath registers
  logic [5:0]         cnt_r;
  logic [49:0]        red_rem_r, red_cmp_r;
  logic               dneg_r, neg_r, msign_r, div_saw_r;
  logic signed [33:0] x_r, y_r, c_r;
  logic signed [23:0] z_r;
  logic signed [61:0] mul_r, p1_r;
  logic [34:0]        div_num_r;
  logic [22:0]        div_rem_r, div_den_r;
  logic signed [31:0] arg_r;
  logic [60:0]        sq_rem_r, sq_res_r, sq_bit_r;

  logic               out_valid_r;
  logic signed [31:0] gs_out_r, dist_out_r, hd_out_r;

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    if (v > 63'sd2147483647) return 32'sh7fffffff;
    if (v < -63'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.gnd_speed = gs_out_r;
  assign out_ch.distance_step = dist_out_r;
  assign out_ch.heading_out = hd_out_r;

  // Heading minus wind direction, magnitude for the reduction
  logic signed [32:0] d_w;
  logic [32:0]        dmag_w;
  assign d_w = $signed({h_r[31], h_r}) - $signed({{13{dir_r[19]}}, dir_r});
  assign dmag_w = d_w[32] ? 33'(-d_w) : 33'(d_w);

  // Reduction step
  logic red_ge;
  assign red_ge = red_rem_r >= red_cmp_r;

  // Fold into [-pi/2, pi/2]
  logic signed [36:0] r0_w, rw_w, rt_w;
  logic signed [19:0] zr_w, zf_w;
  logic               fneg_w;
  always_comb begin
    r0_w = dneg_r ? -$signed({2'b0, red_rem_r[34:0]}) : $signed({2'b0, red_rem_r[34:0]});
    if (r0_w > PI_Q32)       rw_w = r0_w - TWO_PI_Q32;
    else if (r0_w < -PI_Q32) rw_w = r0_w + TWO_PI_Q32;
    else                     rw_w = r0_w;
    rt_w = rw_w + 37'sd32768;
    zr_w = rt_w[35:16];
    fneg_w = 1'b0;
    zf_w = zr_w;
    if (zr_w > HALF_PI_Q16) begin
      zf_w = zr_w - PI_Q16;
      fneg_w = 1'b1;
    end else if (zr_w < -HALF_PI_Q16) begin
      zf_w = zr_w + PI_Q16;
      fneg_w = 1'b1;
    end
  end

  // Shared CORDIC stage: rotation in S_ROT, vectoring otherwise
  logic signed [33:0] xs_w, ys_w, x_nxt, y_nxt;
  logic signed [23:0] at_w, z_nxt;
  logic               cpos_w;
  always_comb begin
    xs_w = x_r >>> cnt_r[CIW-1:0];
    ys_w = y_r >>> cnt_r[CIW-1:0];
    at_w = $signed({8'b0, atan_q16(cnt_r)});
    cpos_w = (state_r == S_ROT) ? !z_r[23] : y_r[33];
    if (cpos_w) begin
      x_nxt = x_r - ys_w;
      y_nxt = y_r + xs_w;
      z_nxt = z_r - at_w;
    end else begin
      x_nxt = x_r + ys_w;
      y_nxt = y_r - xs_w;
      z_nxt = z_r + at_w;
    end
  end

  // Shared multiplier
  logic signed [33:0] ma_w, mb_w, s_adj_w;
  logic signed [67:0] prod_w;
  assign s_adj_w = neg_r ? -y_r : y_r;
  always_comb begin
    ma_w = '0;
    mb_w = '0;
    case (state_r)
      S_MWS: begin
        ma_w = $signed({14'b0, wind_r});
        mb_w = s_adj_w;
      end
      S_SQR: begin
        ma_w = 34'(arg_r);
        mb_w = 34'(arg_r);
      end
      S_GS1: begin
        ma_w = $signed({11'b0, air_r});
        mb_w = $signed({3'b0, sq_res_r[30:0]});
      end
      S_GS2: begin
        ma_w = $signed({14'b0, wind_r});
        mb_w = c_r;
      end
      default: ;
    endcase
  end
  assign prod_w = ma_w * mb_w;

  // Asin argument magnitude and saturation check
  logic [54:0] mag_w;
  logic        arg_sat_w;
  assign mag_w = mul_r[61] ? 55'(-mul_r) : 55'(mul_r);
  assign arg_sat_w = {1'b0, mag_w} >= {2'b0, air_r, 31'b0};

  // Shared restoring divider step
  logic [23:0] div_t_w;
  logic        div_ge_w;
  logic [22:0] div_rem_nxt;
  logic [34:0] div_num_nxt;
  logic [30:0] q_clamp_w;
  assign div_t_w = {div_rem_r, div_num_r[34]};
  assign div_ge_w = div_t_w >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge_w ? 23'(div_t_w - {1'b0, div_den_r}) : div_t_w[22:0];
  assign div_num_nxt = {div_num_r[33:0], div_ge_w};
  assign q_clamp_w = (div_num_nxt[30:0] > 31'(ONE_Q30)) ? 31'(ONE_Q30) : div_num_nxt[30:0];

  // Square root step
  logic [61:0] sq_sum_w;
  logic        sq_ge_w;
  logic [60:0] sq_res_nxt;
  assign sq_sum_w = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign sq_ge_w = {1'b0, sq_rem_r} >= sq_sum_w;
  assign sq_res_nxt = sq_ge_w ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;

  // Final combination
  logic signed [62:0] gfull_w, gq_w;
  logic signed [31:0] gs_w;
  assign gfull_w = $signed({p1_r[61], p1_r}) - $signed({mul_r[61], mul_r})
                   + 63'sd536870912;
  assign gq_w = gfull_w >>> 30;
  assign gs_w = sat32(gq_w);

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      air_r       <= 23'd655360;
      base_r      <= '0;
      dir_r       <= '0;
      period_r    <= 16'd10;
      mode_r      <= FM_CONST;
      tick_r      <= '0;
      odd_r       <= 1'b0;
      wind_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      // result taken; a result written in S_FIN keeps the flag set
      if (out_valid_r && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AIR_SPEED: air_r <= cfg_data;
          CFG_BASE_WIND: begin
            base_r <= (cfg_data[18:0] > MAX_WIND_Q16) ? MAX_WIND_Q16 : cfg_data[18:0];
            wind_r <= {1'b0, (cfg_data[18:0] > MAX_WIND_Q16) ? MAX_WIND_Q16
                                                              : cfg_data[18:0]};
          end
          CFG_WIND_DIR:  dir_r <= cfg_data[19:0];
          CFG_FLUC_PER:  period_r <= cfg_data[15:0];
          CFG_FLUC_MODE: mode_r <= cfg_data[1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            h_r   <= in_ch.heading_in;
            gps_r <= in_ch.gps_corr;
            if (tick_r < period_r) tick_r <= tick_r + 16'd1;
            else begin
              tick_r <= 16'd1;
              odd_r  <= ~odd_r;
            end
            state_r <= S_WIND;
          end
        end
        S_WIND: begin
          red_rem_r <= {1'b0, dmag_w, 16'b0};
          red_cmp_r <= RED_CMP0;
          dneg_r    <= d_w[32];
          cnt_r     <= '0;
          if (mode_r == FM_SAW) begin
            div_num_r <= 35'(base_r * tick_r);
            div_rem_r <= '0;
            div_den_r <= (period_r < 16'd2) ? 23'd1 : {7'b0, period_r - 16'd1};
            div_saw_r <= 1'b1;
            state_r   <= S_DIV;
          end else begin
            if (mode_r == FM_PULSE) wind_r <= odd_r ? 20'd0 : {1'b0, base_r};
            state_r <= S_RED;
          end
        end
        S_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_num_r <= div_num_nxt;
          if (div_saw_r && cnt_r == 6'd34) begin
            wind_r  <= div_num_nxt[19:0];
            cnt_r   <= '0;
            state_r <= S_RED;
          end else begin
            cnt_r <= cnt_r + 6'd1;
            if (!div_saw_r && cnt_r == 6'd30) begin
              arg_r   <= msign_r ? -$signed({1'b0, q_clamp_w}) : $signed({1'b0, q_clamp_w});
              state_r <= S_SQR;
            end
          end
        end
        S_RED: begin
          if (red_ge) red_rem_r <= red_rem_r - red_cmp_r;
          red_cmp_r <= red_cmp_r >> 1;
          cnt_r     <= cnt_r + 6'd1;
          if (cnt_r == 6'd14) state_r <= S_FOLD;
        end
        S_FOLD: begin
          x_r     <= CORDIC_GAIN_Q30;
          y_r     <= '0;
          z_r     <= 24'(zf_w);
          neg_r   <= fneg_w;
          cnt_r   <= '0;
          state_r <= S_ROT;
        end
        S_ROT: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == CLAST) state_r <= S_MWS;
        end
        S_MWS: begin
          mul_r   <= prod_w[61:0];
          c_r     <= neg_r ? -x_r : x_r;
          state_r <= S_ARG;
        end
        S_ARG: begin
          msign_r <= mul_r[61];
          if (mag_w == '0) begin
            arg_r   <= '0;
            state_r <= S_SQR;
          end else if (arg_sat_w) begin
            arg_r   <= mul_r[61] ? -ONE_Q30 : ONE_Q30;
            state_r <= S_SQR;
          end else begin
            div_rem_r <= mag_w[53:31];
            div_num_r <= {mag_w[30:0], 4'b0};
            div_den_r <= air_r;
            div_saw_r <= 1'b0;
            cnt_r     <= '0;
            state_r   <= S_DIV;
          end
        end
        S_SQR: begin
          mul_r   <= prod_w[61:0];
          state_r <= S_SQI;
        end
        S_SQI: begin
          sq_rem_r <= SQ_ONE - mul_r[60:0];
          sq_res_r <= '0;
          sq_bit_r <= SQ_ONE;
          cnt_r    <= '0;
          state_r  <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge_w) sq_rem_r <= sq_rem_r - sq_sum_w[60:0];
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          if (cnt_r == 6'd30) begin
            x_r     <= $signed({3'b0, sq_res_nxt[30:0]});
            y_r     <= 34'(arg_r);
            z_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_VEC;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_VEC: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == CLAST) state_r <= S_GS1;
        end
        S_GS1: begin
          mul_r   <= prod_w[61:0];
          state_r <= S_GS2;
        end
        S_GS2: begin
          p1_r    <= mul_r;
          mul_r   <= prod_w[61:0];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            gs_out_r    <= gs_w;
            dist_out_r  <= sat32(63'($signed({gs_w[31], gs_w}) + $signed({gps_r[31], gps_r})));
            hd_out_r    <= sat32(63'($signed({h_r[31], h_r}) + $signed({{9{z_r[23]}}, z_r})));
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  `AST_IMPLIES(a_arg_range, clk, rst_n, state_r == S_SQR, (arg_r <= ONE_Q30 && arg_r >= -ONE_Q30))
  `AST_NEXT(a_tick_nonzero, clk, rst_n, accept, tick_r != 16'd0)
  `AST_IMPLIES(a_sqrt_bound, clk, rst_n, state_r == S_GS1, sq_res_r <= SQ_ONE >> 30)
  `AST_IMPLIES(a_cordic_cnt, clk, rst_n, state_r == S_ROT || state_r == S_VEC, cnt_r <= CLAST)

endmodule

// ===== tb/sv/wtgt_track_checker.sv =====
// Scoreboard for the wind triangle core: predicts each result and compares it.
module wtgt_track_checker (
  input  logic                clk,
  input  logic                rst_n,
  wtgt_in_if                  in_ch,
  wtgt_out_if                 out_ch,
  input  logic                cfg_we,
  input  wtgt_pkg::cfg_idx_t  cfg_index,
  input  wtgt_pkg::cfg_data_t cfg_data,
  output int                  err_count,
  output int                  pending
);
  import wtgt_pkg::*;

  localparam int STEPS = 16;
  localparam longint TWO_PI_L = 64'sd26986075409;
  localparam longint PI_L     = 64'sd13493037705;
  localparam longint GAIN_L   = 64'sd652032874;
  localparam longint ONE_L    = 64'sd1073741824;

  typedef struct packed {
    logic signed [31:0] gs;
    logic signed [31:0] dstep;
    logic signed [31:0] hdg;
  } track_t;

  track_t track_q[$];

  // Shadow registers and wind state
  logic [22:0]        air_spd;
  logic [18:0]        base_wind;
  logic signed [19:0] wind_dir;
  logic [15:0]        fl_period;
  logic [1:0]         fl_mode;
  logic [15:0]        tick_cnt;
  logic               odd_per;
  logic [31:0]        cur_wind;

  function automatic longint atan_step(input int i);
    longint head[7];
    head = '{51472, 30386, 16055, 8150, 4091, 2047, 1024};
    if (i < 7) return head[i];
    if (i <= 16) return longint'(1) << (16 - i);
    return 0;
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned rem, res, bt;
    rem = n;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Advances the wind state and solves the triangle for one request
  function automatic track_t solve_track(input logic signed [31:0] hd,
                                         input logic signed [31:0] gps_err);
    longint h, d, r, z, x, y, nx, s30, c30, ws, arg, sq, wca, gs;
    longint unsigned dv;
    bit neg;
    track_t t;
    h = hd;
    neg = 0;
    if (tick_cnt < fl_period) begin
      tick_cnt = tick_cnt + 1;
    end else begin
      tick_cnt = 1;
      odd_per = ~odd_per;
    end
    if (fl_mode == FM_SAW) begin
      dv = (fl_period < 2) ? 1 : longint'(fl_period) - 1;
      cur_wind = 32'((longint'(base_wind) * longint'(tick_cnt)) / dv);
    end else if (fl_mode == FM_PULSE) begin
      cur_wind = odd_per ? 32'd0 : 32'(base_wind);
    end
    // angle reduction to [-pi/2, pi/2] with sign fold
    d = h - longint'(wind_dir);
    r = (d * 65536) % TWO_PI_L;
    if (r > PI_L) r = r - TWO_PI_L;
    else if (r < -PI_L) r = r + TWO_PI_L;
    z = (r + 32768) >>> 16;
    if (z > longint'(HALF_PI_Q16)) begin
      z = z - longint'(PI_Q16);
      neg = 1;
    end else if (z < -longint'(HALF_PI_Q16)) begin
      z = z + longint'(PI_Q16);
      neg = 1;
    end
    // rotation mode: sin and cos in Q30
    x = GAIN_L;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_step(i);
      end
      x = nx;
    end
    s30 = neg ? -y : y;
    c30 = neg ? -x : x;
    // asin argument, saturated to one
    ws = longint'(cur_wind);
    arg = ws * s30;
    if (air_spd == 0) arg = (arg > 0) ? ONE_L : ((arg < 0) ? -ONE_L : 0);
    else arg = arg / longint'(air_spd);
    if (arg > ONE_L) arg = ONE_L;
    else if (arg < -ONE_L) arg = -ONE_L;
    sq = longint'(root_floor(longint'(ONE_L * ONE_L - arg * arg)));
    // vectoring mode: atan2(arg, sq)
    x = sq;
    y = arg;
    wca = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        wca = wca + atan_step(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        wca = wca - atan_step(i);
      end
      x = nx;
    end
    gs = longint'(air_spd) * sq - ws * c30;
    gs = sat32((gs + (longint'(1) << 29)) >>> 30);
    t.gs = 32'(gs);
    t.dstep = 32'(sat32(gs + longint'(gps_err)));
    t.hdg = 32'(sat32(h + wca));
    return t;
  endfunction

  task automatic check_field(input string nm, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, nm, exp_v, act_v);
      err_count++;
    end
  endtask

  assign pending = track_q.size();

  always @(posedge clk) begin
    track_t t;
    if (!rst_n) begin
      air_spd   <= 23'd655360;
      base_wind <= '0;
      wind_dir  <= '0;
      fl_period <= 16'd10;
      fl_mode   <= FM_CONST;
      tick_cnt  <= '0;
      odd_per   <= 1'b0;
      cur_wind  <= '0;
      track_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_AIR_SPEED: air_spd <= cfg_data;
          CFG_BASE_WIND: begin
            base_wind <= (cfg_data[18:0] > MAX_WIND_Q16) ? MAX_WIND_Q16 : cfg_data[18:0];
            cur_wind <= (cfg_data[18:0] > MAX_WIND_Q16) ? 32'(MAX_WIND_Q16)
                                                        : 32'(cfg_data[18:0]);
          end
          CFG_WIND_DIR:  wind_dir <= cfg_data[19:0];
          CFG_FLUC_PER:  fl_period <= cfg_data[15:0];
          CFG_FLUC_MODE: fl_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      // accepted request
      if (in_ch.valid && in_ch.ready)
        track_q.push_back(solve_track(in_ch.heading_in, in_ch.gps_corr));
      // accepted result
      if (out_ch.valid && out_ch.ready) begin
        if (track_q.size() == 0) begin
          $display("%0t: unexpected result: gs %h step %h hdg %h", $time,
                   out_ch.gnd_speed, out_ch.distance_step, out_ch.heading_out);
          err_count++;
        end else begin
          t = track_q.pop_front();
          check_field("gnd_speed", t.gs, out_ch.gnd_speed);
          check_field("distance_step", t.dstep, out_ch.distance_step);
          check_field("heading_out", t.hdg, out_ch.heading_out);
        end
      end
    end
  end

  initial err_count = 0;

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the wind triangle core testbench: clock, reset, stimulus and verdict.
module tb_top;
  import wtgt_pkg::*;

  localparam int SETTLE    = 200;
  localparam int CYC_LIMIT = 3000000;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;
  int        err_count;
  int        pending;
  int        tx_idle;
  int        rx_idle;
  int        cyc = 0;

  wtgt_in_if  in_if ();
  wtgt_out_if out_if ();

  wind_triangle_ground_track_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wtgt_track_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side stalls
  always @(posedge clk) out_if.ready <= ($urandom_range(99) >= rx_idle);

  // run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_req(input logic [31:0] hd, input logic [31:0] gps);
    while ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.heading_in <= hd;
    in_if.gps_corr   <= gps;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop sending and wait for the core to go idle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_all(input logic [22:0] air, input logic [22:0] wind,
                         input logic signed [19:0] dir, input logic [15:0] per,
                         input logic [1:0] mode);
    cfg_we <= 1'b1; cfg_index <= CFG_AIR_SPEED; cfg_data <= air;
    @(posedge clk);
    cfg_index <= CFG_BASE_WIND; cfg_data <= wind;
    @(posedge clk);
    cfg_index <= CFG_WIND_DIR; cfg_data <= 23'(unsigned'(dir));
    @(posedge clk);
    cfg_index <= CFG_FLUC_PER; cfg_data <= 23'(per);
    @(posedge clk);
    cfg_index <= CFG_FLUC_MODE; cfg_data <= 23'(mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random();
    logic [31:0] hd, gps;
    case ($urandom_range(3))
      0: hd = $urandom;
      1: hd = 32'($signed($urandom_range(0, 823550)) - 411775);
      default: hd = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
    gps = ($urandom_range(3) == 0) ? $urandom
                                   : 32'($signed($urandom_range(0, 131072)) - 65536);
    send_req(hd, gps);
  endtask

  initial begin
    int np;
    logic [15:0] per;
    tx_idle = 0;
    rx_idle = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_AIR_SPEED;
    cfg_data <= '0;
    in_if.valid <= 1'b0;
    in_if.heading_in <= '0;
    in_if.gps_corr <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, then fold boundaries and output saturation
    send_req(32'd0, 32'd0);
    send_req(32'd102944, 32'h7fffffff);
    send_req(32'd102945, 32'h80000000);
    send_req(32'd205887, 32'd65536);
    send_req(-32'sd205887, -32'sd65536);
    drain();

    // slowest airspeed, clamped wind, period zero, on/off wind
    cfg_all(23'd65536, 23'h7ffff, 20'sd411775, 16'd0, FM_PULSE);
    send_req(32'h7fffffff, 32'h7fffffff);
    send_req(32'h80000000, 32'h80000000);
    send_req(32'd102944, 32'h0);
    send_req(-32'sd102944, 32'h0);
    send_req(32'd51472, 32'h7fff0000);
    drain();

    // zero airspeed, unused mode, period one
    cfg_all(23'd0, 23'd265420, -20'sd411775, 16'd1, FM_RSVD);
    send_req(32'd102944, 32'd0);
    send_req(-32'sd102944, 32'd0);
    send_req(-32'sd411775, 32'd0);
    send_req(32'd400000, 32'd12345);
    drain();

    // fastest airspeed, sawtooth at the shortest and longest period
    cfg_all(23'd6553600, 23'd265420, 20'sd0, 16'd2, FM_SAW);
    send_req(32'd102944, 32'd1);
    send_req(32'd205887, 32'd2);
    send_req(32'd0, 32'd3);
    drain();
    cfg_all(23'd65536, 23'd265419, 20'sd0, 16'd65535, FM_SAW);
    send_req(32'd102944, 32'd0);
    send_req(-32'sd102944, 32'd0);
    send_req(32'd1, 32'd0);
    drain();

    // random part in three stall profiles, new settings every so often
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 18 : ((ph == 1) ? 60 : 0);
      rx_idle = (ph == 0) ? 60 : ((ph == 1) ? 18 : 0);
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(4))
          0: per = 16'($urandom_range(0, 3));
          1: per = 16'($urandom_range(60000, 65535));
          default: per = 16'($urandom_range(2, 20));
        endcase
        cfg_all(($urandom_range(9) == 0) ? 23'd65536 : 23'($urandom_range(65536, 6553600)),
                ($urandom_range(7) == 0) ? 23'($urandom_range(0, 524287))
                                         : 23'($urandom_range(0, 265420)),
                20'($signed($urandom_range(0, 823550)) - 411775),
                per, 2'($urandom_range(3)));
        np = 98;
        for (int k = 0; k < np; k++) send_random();
        drain();
      end
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
